/* src/pcxrle_pkg.sv */
package pcxrle_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int RUN_BITS       = 6;
    localparam int TOTAL_BITS     = 24;
    localparam int RGB_BITS       = 24;
    localparam int CFG_INDEX_BITS = 8;

    localparam logic [BYTE_BITS-1:0] RUN_MARK = 8'd192;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PALETTE_ENABLE = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTPUT_TOTAL   = 8'd1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic start;
        logic last;
        logic out_free;
        logic error;
        logic frame_full;
    } t_dp_sts;

endpackage

/* src/pcx_rle_palette_decoder_top.sv */
// Run-length expander for PCX image data with optional 256-entry palette lookup.
// A palette load or a count byte produces no output. A value byte gives one element of
// its run per cycle while the output is free (1 to 63 elements, or a single overflow
// result), paced by the run counter that feeds the output register; input ready stays
// low while a run is expanded. A value byte whose run is zero produces nothing unless an
// error or a full frame gives an overflow result. The palette is a RAM with a registered
// read issued when the value byte is accepted; entries must be loaded before use.
// Configuration writes are taken in any cycle and must only be issued while idle.
module pcx_rle_palette_decoder_top #(
    parameter int COUNT_BITS    = 24,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pcxrle_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [pcxrle_pkg::TOTAL_BITS-1:0]     i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_command,
    input  logic [pcxrle_pkg::BYTE_BITS-1:0]      i_data_byte,
    input  logic [pcxrle_pkg::BYTE_BITS-1:0]      i_entry_index,
    input  logic [pcxrle_pkg::BYTE_BITS-1:0]      i_entry_red,
    input  logic [pcxrle_pkg::BYTE_BITS-1:0]      i_entry_green,
    input  logic [pcxrle_pkg::BYTE_BITS-1:0]      i_entry_blue,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [pcxrle_pkg::BYTE_BITS-1:0]      o_raw_value,
    output logic [pcxrle_pkg::BYTE_BITS-1:0]      o_out_red,
    output logic [pcxrle_pkg::BYTE_BITS-1:0]      o_out_green,
    output logic [pcxrle_pkg::BYTE_BITS-1:0]      o_out_blue,
    output logic                                  o_last_of_run,
    output logic                                  o_frame_done,
    output logic                                  o_overflow_error
);

    pcxrle_pkg::t_dp_cmd cmd;
    pcxrle_pkg::t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    pcxrle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pcxrle_dpath #(
        .COUNT_BITS    (COUNT_BITS),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_command),
        .i_data_byte      (i_data_byte),
        .i_entry_index    (i_entry_index),
        .i_entry_red      (i_entry_red),
        .i_entry_green    (i_entry_green),
        .i_entry_blue     (i_entry_blue),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_raw_value      (o_raw_value),
        .o_out_red        (o_out_red),
        .o_out_green      (o_out_green),
        .o_out_blue       (o_out_blue),
        .o_last_of_run    (o_last_of_run),
        .o_frame_done     (o_frame_done),
        .o_overflow_error (o_overflow_error)
    );

    // overflow results carry no color and no run or frame markers
    a_ovf_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow_error) |->
            (!o_last_of_run && !o_frame_done && o_out_red == '0 &&
             o_out_green == '0 && o_out_blue == '0))
        else $error("overflow result with nonzero fields");

    // the error stays latched until reset
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.error |=> sts.error)
        else $error("error latch cleared");

    // a frame done element means the element count has reached the total
    a_done_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> sts.frame_full)
        else $error("frame done shown before frame full");

endmodule

/* src/pcxrle_ram.sv */
module pcxrle_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/pcxrle_ctrl.sv */
module pcxrle_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pcxrle_pkg::t_dp_sts i_sts,
    output pcxrle_pkg::t_dp_cmd o_cmd
);

    pcxrle_pkg::t_state r_state;
    pcxrle_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcxrle_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pcxrle_pkg::ST_IDLE: begin
                if (i_in_valid && i_sts.start) begin
                    n_state = pcxrle_pkg::ST_EMIT;
                end
            end
            pcxrle_pkg::ST_EMIT: begin
                if (i_sts.out_free && i_sts.last) begin
                    n_state = pcxrle_pkg::ST_IDLE;
                end
            end
            default: n_state = pcxrle_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.load   = 1'b0;
        case (r_state)
            pcxrle_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            pcxrle_pkg::ST_EMIT: begin
                o_cmd.load = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* src/pcxrle_dpath.sv */
module pcxrle_dpath #(
    parameter int COUNT_BITS    = 24,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pcxrle_pkg::t_dp_cmd                    i_cmd,
    output pcxrle_pkg::t_dp_sts                    o_sts,
    input  logic                                   i_cfg_valid,
    input  logic [pcxrle_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [pcxrle_pkg::TOTAL_BITS-1:0]      i_cfg_data,
    input  logic                                   i_command,
    input  logic [pcxrle_pkg::BYTE_BITS-1:0]       i_data_byte,
    input  logic [pcxrle_pkg::BYTE_BITS-1:0]       i_entry_index,
    input  logic [pcxrle_pkg::BYTE_BITS-1:0]       i_entry_red,
    input  logic [pcxrle_pkg::BYTE_BITS-1:0]       i_entry_green,
    input  logic [pcxrle_pkg::BYTE_BITS-1:0]       i_entry_blue,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [pcxrle_pkg::BYTE_BITS-1:0]       o_raw_value,
    output logic [pcxrle_pkg::BYTE_BITS-1:0]       o_out_red,
    output logic [pcxrle_pkg::BYTE_BITS-1:0]       o_out_green,
    output logic [pcxrle_pkg::BYTE_BITS-1:0]       o_out_blue,
    output logic                                   o_last_of_run,
    output logic                                   o_frame_done,
    output logic                                   o_overflow_error
);

    localparam int ADDR_W = $clog2(PALETTE_DEPTH);
    localparam int WB = (COUNT_BITS > pcxrle_pkg::TOTAL_BITS) ? COUNT_BITS
                                                             : pcxrle_pkg::TOTAL_BITS;

    // configuration
    logic                              r_palette_enable;
    logic [pcxrle_pkg::TOTAL_BITS-1:0] r_output_total;

    // decoder state
    logic                              r_value_expected;
    logic [pcxrle_pkg::RUN_BITS-1:0]   r_pending;
    logic [COUNT_BITS-1:0]             r_written;
    logic                              r_error;

    // current run
    logic [pcxrle_pkg::BYTE_BITS-1:0]  r_byte;
    logic [pcxrle_pkg::RUN_BITS-1:0]   r_left;
    logic                              r_ovf;

    // output register
    logic                              r_out_valid;
    logic [pcxrle_pkg::BYTE_BITS-1:0]  r_raw_value;
    logic [pcxrle_pkg::RGB_BITS-1:0]   r_rgb;
    logic                              r_last;
    logic                              r_done;
    logic                              r_err_out;

    logic [WB-1:0]                     total_w;
    logic [WB-1:0]                     cap_w;
    logic [WB-1:0]                     total_c;
    logic [COUNT_BITS-1:0]             total_cb;
    logic [COUNT_BITS-1:0]             room;
    logic [COUNT_BITS-1:0]             written_inc;
    logic                              frame_full;
    logic                              is_data;
    logic                              is_count;
    logic                              is_value;
    logic [pcxrle_pkg::RUN_BITS-1:0]   run;
    logic                              ovf_cond;
    logic                              ram_we;
    logic                              ram_re;
    logic [pcxrle_pkg::RGB_BITS-1:0]   ram_rdata;
    logic                              out_free;

    // total capped to what the element counter can hold
    assign total_w  = WB'(r_output_total);
    assign cap_w    = ~(WB'(0)) >> (WB - COUNT_BITS);
    assign total_c  = (total_w > cap_w) ? cap_w : total_w;
    assign total_cb = total_c[COUNT_BITS-1:0];

    assign frame_full  = (r_written >= total_cb);
    assign room        = total_cb - r_written;
    assign written_inc = r_written + COUNT_BITS'(1);

    assign is_data  = (i_command == pcxrle_pkg::CMD_DATA);
    assign is_count = is_data && !r_value_expected && (i_data_byte >= pcxrle_pkg::RUN_MARK);
    assign is_value = is_data && !is_count;
    assign run      = r_value_expected ? r_pending : pcxrle_pkg::RUN_BITS'(1);
    assign ovf_cond = r_error || frame_full || (COUNT_BITS'(run) > room);

    assign ram_we = i_cmd.accept && (i_command == pcxrle_pkg::CMD_LOAD);
    assign ram_re = i_cmd.accept && is_value;

    pcxrle_ram #(
        .WIDTH (pcxrle_pkg::RGB_BITS),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_entry_index[ADDR_W-1:0]),
        .i_wdata ({i_entry_red, i_entry_green, i_entry_blue}),
        .i_re    (ram_re),
        .i_raddr (i_data_byte[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_enable <= 1'b0;
            r_output_total   <= pcxrle_pkg::TOTAL_BITS'(1);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == pcxrle_pkg::CFG_PALETTE_ENABLE) begin
                r_palette_enable <= i_cfg_data[0];
            end else if (i_cfg_index == pcxrle_pkg::CFG_OUTPUT_TOTAL) begin
                r_output_total <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_expected <= 1'b0;
            r_pending        <= '0;
            r_written        <= '0;
            r_error          <= 1'b0;
            r_left           <= '0;
            r_ovf            <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cmd.accept && is_count) begin
                r_value_expected <= 1'b1;
                r_pending        <= pcxrle_pkg::RUN_BITS'(i_data_byte - pcxrle_pkg::RUN_MARK);
            end else if (i_cmd.accept && is_value) begin
                r_value_expected <= 1'b0;
                r_pending        <= '0;
                r_left           <= run;
                r_ovf            <= ovf_cond;
                if (ovf_cond) begin
                    r_error <= 1'b1;
                end
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
                if (!r_ovf) begin
                    r_written <= written_inc;
                    r_left    <= r_left - pcxrle_pkg::RUN_BITS'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && is_value) begin
            r_byte <= i_data_byte;
        end
        if (i_cmd.load) begin
            r_raw_value <= r_byte;
            r_rgb       <= (r_palette_enable && !r_ovf) ? ram_rdata : '0;
            r_last      <= !r_ovf && (r_left == pcxrle_pkg::RUN_BITS'(1));
            r_done      <= !r_ovf && (written_inc == total_cb);
            r_err_out   <= r_ovf;
        end
    end

    assign o_sts.start      = is_value && (ovf_cond || (run != '0));
    assign o_sts.last       = r_ovf || (r_left == pcxrle_pkg::RUN_BITS'(1));
    assign o_sts.out_free   = out_free;
    assign o_sts.error      = r_error;
    assign o_sts.frame_full = frame_full;

    assign o_out_valid      = r_out_valid;
    assign o_raw_value      = r_raw_value;
    assign o_out_red        = r_rgb[23:16];
    assign o_out_green      = r_rgb[15:8];
    assign o_out_blue       = r_rgb[7:0];
    assign o_last_of_run    = r_last;
    assign o_frame_done     = r_done;
    assign o_overflow_error = r_err_out;

endmodule
